[rtl/core/fifo_handoff_mutex_assert.svh]
// Assertion macros used by the lock block's top-level RTL file.
`ifndef FIFO_HANDOFF_MUTEX_ASSERT_SVH
`define FIFO_HANDOFF_MUTEX_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define FHM_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FHM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/fhm_pkg.sv]
// Package with the operation and status codes and the default sizes of the lock block.
`default_nettype none

package fhm_pkg;

    // Field widths of the request and result items.
    localparam int OP_W       = 3;
    localparam int TID_W      = 8;
    localparam int ST_W       = 2;
    localparam int WAITERS_W  = 5;

    // Default sizes.
    localparam int THREADS_DEF    = 256;
    localparam int WAIT_DEPTH_DEF = 16;

    // Request operations.
    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_DESTROY = 3'd1,
        OP_LOCK    = 3'd2,
        OP_TRYLOCK = 3'd3,
        OP_UNLOCK  = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_QUEUED = 2'd1,
        ST_ERROR  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

endpackage

`default_nettype wire

[rtl/core/fifo_handoff_mutex.sv]
// Top level of the hardware lock with a first-in first-out queue of waiting threads.
//
// Each request item carries an operation (init, destroy, lock, trylock, unlock)
// and a thread id, and produces exactly one result item in the cycle after it is
// accepted. The block takes one item per cycle: the result sits in an output
// register, and a new item is accepted whenever that register is empty or is
// being emptied in the same cycle. The waiting threads live in a RAM of
// WAIT_DEPTH entries with a registered read; the RAM read port
// always fetches the entry at the next head of the queue, and a forwarding
// register covers the case where a lock pushes into the entry that becomes
// the head, so an unlock can hand the lock to the oldest waiter in the same
// cycle it is accepted. No clearing pass is needed after reset.
`default_nettype none

`include "fifo_handoff_mutex_assert.svh"

module fifo_handoff_mutex #(
    parameter int THREADS    = fhm_pkg::THREADS_DEF,
    parameter int WAIT_DEPTH = fhm_pkg::WAIT_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [fhm_pkg::OP_W-1:0]      s_op,
    input  wire logic [fhm_pkg::TID_W-1:0]     s_thread_id,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [fhm_pkg::ST_W-1:0]           m_status,
    output logic                               m_wake_valid,
    output logic [fhm_pkg::TID_W-1:0]          m_wake_thread,
    output logic                               m_lock_held,
    output logic [fhm_pkg::TID_W-1:0]          m_lock_owner,
    output logic [fhm_pkg::WAITERS_W-1:0]      m_waiters
);

    localparam int PW = $clog2(WAIT_DEPTH);
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int TW = fhm_pkg::TID_W;

    // Lock state.
    logic          held_reg,   held_next;
    logic [TW-1:0] owner_reg,  owner_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;

    // Forwarding of a push into the entry that is read next.
    logic          fwd_valid_reg, fwd_valid_next;
    logic [TW-1:0] fwd_data_reg;

    // Output register.
    logic                           m_valid_reg,       m_valid_next;
    logic [fhm_pkg::ST_W-1:0]       m_status_reg,      status_next;
    logic                           m_wake_valid_reg,  wake_valid_next;
    logic [TW-1:0]                  m_wake_thread_reg, wake_thread_next;
    logic                           m_lock_held_reg;
    logic [TW-1:0]                  m_lock_owner_reg,  lock_owner_next;
    logic [fhm_pkg::WAITERS_W-1:0]  m_waiters_reg;

    logic          accept;
    logic          req_legal;
    logic          ram_we;
    logic [TW-1:0] ram_rdata;
    logic [TW-1:0] head_data;
    logic [PW-1:0] rd_ptr_inc;
    logic [PW-1:0] wr_ptr_inc;
    logic [31:0]   cnt_ext;
    fhm_pkg::op_t  op;

    // Handshake: a new item enters when the output register is empty or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign op        = fhm_pkg::op_t'(s_op);
    assign req_legal = (s_op <= fhm_pkg::OP_UNLOCK) && (32'(s_thread_id) < 32'(THREADS));

    // Queue pointer wrap.
    assign rd_ptr_inc = (rd_ptr_reg == PW'(WAIT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PW'(WAIT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    // Oldest waiter, from the RAM or from the forwarding register.
    assign head_data = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // Request decode and state update.
    always_comb begin
        held_next        = held_reg;
        owner_next       = owner_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        cnt_next         = cnt_reg;
        status_next      = fhm_pkg::ST_ERROR;
        wake_valid_next  = 1'b0;
        wake_thread_next = '0;
        ram_we           = 1'b0;

        if (accept && req_legal) begin
            unique case (op)
                fhm_pkg::OP_INIT: begin
                    held_next   = 1'b0;
                    owner_next  = '0;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    cnt_next    = '0;
                    status_next = fhm_pkg::ST_OK;
                end
                fhm_pkg::OP_DESTROY: begin
                    if (!held_reg && cnt_reg == '0) begin
                        owner_next  = '0;
                        rd_ptr_next = '0;
                        wr_ptr_next = '0;
                        status_next = fhm_pkg::ST_OK;
                    end
                end
                fhm_pkg::OP_LOCK: begin
                    if (!held_reg) begin
                        held_next   = 1'b1;
                        owner_next  = s_thread_id;
                        status_next = fhm_pkg::ST_OK;
                    end else if (owner_reg == s_thread_id) begin
                        status_next = fhm_pkg::ST_ERROR;
                    end else if (cnt_reg >= CW'(WAIT_DEPTH)) begin
                        status_next = fhm_pkg::ST_FULL;
                    end else begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_inc;
                        cnt_next    = cnt_reg + 1'b1;
                        status_next = fhm_pkg::ST_QUEUED;
                    end
                end
                fhm_pkg::OP_TRYLOCK: begin
                    if (!held_reg) begin
                        held_next   = 1'b1;
                        owner_next  = s_thread_id;
                        status_next = fhm_pkg::ST_OK;
                    end
                end
                fhm_pkg::OP_UNLOCK: begin
                    if (held_reg && owner_reg == s_thread_id) begin
                        if (cnt_reg != '0) begin
                            rd_ptr_next      = rd_ptr_inc;
                            cnt_next         = cnt_reg - 1'b1;
                            owner_next       = head_data;
                            wake_valid_next  = 1'b1;
                            wake_thread_next = head_data;
                        end else begin
                            held_next  = 1'b0;
                            owner_next = '0;
                        end
                        status_next = fhm_pkg::ST_OK;
                    end
                end
                default: begin
                    status_next = fhm_pkg::ST_ERROR;
                end
            endcase
        end
    end

    // Result fields that follow from the updated state.
    assign lock_owner_next = held_next ? owner_next : '0;
    assign cnt_ext         = 32'(cnt_next);
    assign m_valid_next    = accept ? 1'b1 : (m_valid_reg && !m_ready);

    // A push into the entry that the RAM reads next must be forwarded.
    assign fwd_valid_next = ram_we && (wr_ptr_reg == rd_ptr_next);

    fhm_ram #(
        .WIDTH (TW),
        .DEPTH (WAIT_DEPTH)
    ) u_queue_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (s_thread_id),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            held_reg      <= held_next;
            owner_reg     <= owner_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cnt_reg       <= cnt_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        fwd_data_reg <= s_thread_id;
        if (accept) begin
            m_status_reg      <= status_next;
            m_wake_valid_reg  <= wake_valid_next;
            m_wake_thread_reg <= wake_thread_next;
            m_lock_held_reg   <= held_next;
            m_lock_owner_reg  <= lock_owner_next;
            m_waiters_reg     <= cnt_ext[fhm_pkg::WAITERS_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_wake_valid  = m_wake_valid_reg;
    assign m_wake_thread = m_wake_thread_reg;
    assign m_lock_held   = m_lock_held_reg;
    assign m_lock_owner  = m_lock_owner_reg;
    assign m_waiters     = m_waiters_reg;

    // The queue never holds more entries than it has.
    `FHM_ASSERT_SAME(a_count_bound, 1'b1, 32'(cnt_reg) <= 32'(WAIT_DEPTH), "wait count overflow")
    // Threads wait only while the lock is held.
    `FHM_ASSERT_SAME(a_wait_held, cnt_reg != '0, held_reg, "waiters on a free lock")
    // Empty or full queue means the pointers meet.
    `FHM_ASSERT_SAME(a_ptr_meet, cnt_reg == '0 || 32'(cnt_reg) == 32'(WAIT_DEPTH), wr_ptr_reg == rd_ptr_reg, "queue pointers disagree with count")
    // A handoff reports the old head as woken and as the new owner.
    `FHM_ASSERT_NEXT(a_handoff, accept && wake_valid_next, m_wake_thread_reg == $past(head_data) && owner_reg == $past(head_data), "handoff lost the head waiter")
    // A woken thread always comes with a successful, held result.
    `FHM_ASSERT_SAME(a_wake_ok, m_valid_reg && m_wake_valid_reg, m_status_reg == fhm_pkg::ST_OK && m_lock_held_reg, "wake without ownership")

endmodule

`default_nettype wire

[rtl/core/fhm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module fhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address written
    // in the same cycle returns the old contents.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
